// ===== hdl/vnfd_pkg.sv =====
// Package for the vertex normal format decoder: format codes, float constants,
// pipeline depth and the lane request type. No dependencies.
package vnfd_pkg;

    localparam logic [2:0] FMT_FLOAT3  = 3'd0;
    localparam logic [2:0] FMT_HALF2   = 3'd1;
    localparam logic [2:0] FMT_DEC3N   = 3'd2;
    localparam logic [2:0] FMT_UBYTE4N = 3'd3;

    localparam logic [31:0] BITS_ONE = 32'h3F80_0000;
    localparam logic [31:0] BITS_INF = 32'h7F80_0000;

    // register stages from accepted input to output register
    localparam int PIPE_DEPTH = 7;

    typedef struct packed {
        logic       is_ub;  // 1: byte/127.5-1, 0: signed 10-bit field/511
        logic [9:0] field;
    } lane_in_t;

endpackage

// ===== hdl/vnfd_in_if.sv =====
// Input channel of the vertex normal format decoder (valid/ready + payload).
// No dependencies.
interface vnfd_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [31:0] word_x;
    logic [31:0] word_y;
    logic [31:0] word_z;

    modport source (output valid, output op, output word_x, output word_y, output word_z,
                    input ready);
    modport sink   (input valid, input op, input word_x, input word_y, input word_z,
                    output ready);
endinterface

// ===== hdl/vnfd_out_if.sv =====
// Output channel of the vertex normal format decoder (valid/ready + payload).
// No dependencies.
interface vnfd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;

    modport source (output valid, output norm_x, output norm_y, output norm_z, input ready);
    modport sink   (input valid, input norm_x, input norm_y, input norm_z, output ready);
endinterface

// ===== hdl/vertex_normal_format_decoder_unit.sv =====
// Vertex normal format decoder: packed normal to three single-precision words.
// Throughput one item per cycle while the output is not stalled, set by the
// seven-stage conversion lanes which all advance together.
// A stalled output holds every stage; the input takes a transfer whenever the
// output register is empty or being drained.
// Reset (rst_n, async, active low) clears the stage valid bits only.
module vertex_normal_format_decoder_unit
    import vnfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    vnfd_in_if.sink    req,
    vnfd_out_if.source rsp
);

    // pipeline advance: whole pipe moves unless the output holds an untaken result
    logic en;
    logic [PIPE_DEPTH-1:0] v_reg;

    assign en        = !v_reg[PIPE_DEPTH-1] || rsp.ready;
    assign req.ready = en;
    assign rsp.valid = v_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[PIPE_DEPTH-2:0], req.valid};
        end
    end

    // half to single: exact, denormals normalized, Inf/NaN payload kept
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0] ex;
        logic [9:0] man;
        logic [3:0] sh;
        logic [9:0] mn;
        ex  = h[14:10];
        man = h[9:0];
        sh  = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (man[i])
            begin
                sh = 4'(10 - i);
            end
        end
        mn = man << sh;
        if (ex == 5'h1F)
        begin
            half_to_single = {h[15], 31'd0} | BITS_INF | {9'd0, man, 13'd0};
        end
        else if (ex == 5'd0)
        begin
            if (man == 10'd0)
            begin
                half_to_single = {h[15], 31'd0};
            end
            else
            begin
                half_to_single = {h[15], 8'd113 - {4'd0, sh}, mn, 13'd0};
            end
        end
        else
        begin
            half_to_single = {h[15], {3'd0, ex} + 8'd112, man, 13'd0};
        end
    endfunction

    // formats that need no lane: float3, half pair, default normal
    logic [31:0] px, py, pz;

    always_comb
    begin
        unique case (req.op)
            FMT_FLOAT3:
            begin
                px = req.word_x;
                py = req.word_y;
                pz = req.word_z;
            end
            FMT_HALF2:
            begin
                px = half_to_single(req.word_x[15:0]);
                py = half_to_single(req.word_x[31:16]);
                pz = 32'd0;
            end
            default:
            begin
                px = 32'd0;
                py = BITS_ONE;
                pz = 32'd0;
            end
        endcase
    end

    // carry op and pass-through words alongside the lanes
    logic [2:0]  op_reg [PIPE_DEPTH];
    logic [95:0] pass_reg [PIPE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg[0]   <= req.op;
            pass_reg[0] <= {px, py, pz};
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                op_reg[i]   <= op_reg[i-1];
                pass_reg[i] <= pass_reg[i-1];
            end
        end
    end

    // packed formats: one lane per component
    lane_in_t    lx, ly, lz;
    logic        is_ub;
    logic [31:0] rx, ry, rz;

    assign is_ub = (req.op == FMT_UBYTE4N);
    assign lx = '{is_ub: is_ub, field: is_ub ? {2'd0, req.word_x[7:0]}   : req.word_x[9:0]};
    assign ly = '{is_ub: is_ub, field: is_ub ? {2'd0, req.word_x[15:8]}  : req.word_x[19:10]};
    assign lz = '{is_ub: is_ub, field: is_ub ? {2'd0, req.word_x[23:16]} : req.word_x[29:20]};

    vnfd_lane u_lane_x (.clk(clk), .en(en), .lin(lx), .res(rx));
    vnfd_lane u_lane_y (.clk(clk), .en(en), .lin(ly), .res(ry));
    vnfd_lane u_lane_z (.clk(clk), .en(en), .lin(lz), .res(rz));

    // select lane or pass-through result at the last stage
    logic use_lane;

    assign use_lane   = (op_reg[PIPE_DEPTH-1] == FMT_DEC3N)
                     || (op_reg[PIPE_DEPTH-1] == FMT_UBYTE4N);
    assign rsp.norm_x = use_lane ? rx : pass_reg[PIPE_DEPTH-1][95:64];
    assign rsp.norm_y = use_lane ? ry : pass_reg[PIPE_DEPTH-1][63:32];
    assign rsp.norm_z = use_lane ? rz : pass_reg[PIPE_DEPTH-1][31:0];

endmodule

// ===== hdl/vnfd_lane.sv =====
// One conversion lane: signed 10-bit field / 511 or byte / 127.5 - 1, correctly
// rounded single precision, seven register stages. Depends on vnfd_pkg.
module vnfd_lane
    import vnfd_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  lane_in_t    lin,
    output logic [31:0] res
);

    // stage 1: magnitude and normalize
    logic [9:0] m1;
    logic       sign1;
    logic [3:0] lz1;
    logic       s1_ub_reg, s1_sign_reg, s1_zero_reg;
    logic [9:0] s1_mn_reg;
    logic [3:0] s1_lz_reg;

    always_comb
    begin
        if (lin.is_ub)
        begin
            m1    = {1'b0, lin.field[7:0], 1'b0};
            sign1 = 1'b0;
        end
        else
        begin
            sign1 = lin.field[9];
            m1    = lin.field[9] ? (~lin.field + 10'd1) : lin.field;
        end
        lz1 = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (m1[i])
            begin
                lz1 = 4'(9 - i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ub_reg   <= lin.is_ub;
            s1_sign_reg <= sign1;
            s1_zero_reg <= (m1 == 10'd0);
            s1_mn_reg   <= m1 << lz1;
            s1_lz_reg   <= lz1;
        end
    end

    // stage 2: quotient estimate by reciprocal of the divisor (floor or one less)
    logic [35:0] n2;
    logic [63:0] p511, p255;
    logic        s2_ub_reg, s2_sign_reg, s2_zero_reg;
    logic [3:0]  s2_lz_reg;
    logic [28:0] s2_a_reg;
    logic [35:0] s2_n_reg;

    always_comb
    begin
        n2   = {s1_mn_reg, 26'd0};
        p511 = ({28'd0, n2} << 27) + ({28'd0, n2} << 18) + ({28'd0, n2} << 9) + {28'd0, n2};
        p255 = ({28'd0, n2} << 24) + ({28'd0, n2} << 16) + ({28'd0, n2} << 8) + {28'd0, n2};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_ub_reg   <= s1_ub_reg;
            s2_sign_reg <= s1_sign_reg;
            s2_zero_reg <= s1_zero_reg;
            s2_lz_reg   <= s1_lz_reg;
            s2_n_reg    <= n2;
            s2_a_reg    <= s1_ub_reg ? 29'(p255 >> 32) : 29'(p511 >> 36);
        end
    end

    // stage 3: remainder, one correction step, sticky bit
    logic [35:0] prod3, r3, dv3, rc3;
    logic [28:0] q3;
    logic        st3;
    logic        s3_ub_reg, s3_sign_reg, s3_zero_reg, s3_st_reg;
    logic [3:0]  s3_lz_reg;
    logic [28:0] s3_q_reg;

    always_comb
    begin
        dv3   = s2_ub_reg ? 36'd255 : 36'd511;
        prod3 = s2_ub_reg ? (({7'd0, s2_a_reg} << 8) - {7'd0, s2_a_reg})
                          : (({7'd0, s2_a_reg} << 9) - {7'd0, s2_a_reg});
        r3    = s2_n_reg - prod3;
        rc3   = r3 - dv3;
        if (r3 >= dv3)
        begin
            q3  = s2_a_reg + 29'd1;
            st3 = (rc3 != 36'd0);
        end
        else
        begin
            q3  = s2_a_reg;
            st3 = (r3 != 36'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_ub_reg   <= s2_ub_reg;
            s3_sign_reg <= s2_sign_reg;
            s3_zero_reg <= s2_zero_reg;
            s3_lz_reg   <= s2_lz_reg;
            s3_q_reg    <= q3;
            s3_st_reg   <= st3;
        end
    end

    // stage 4: round quotient to single precision
    logic [23:0] mant4;
    logic        rb4, st4;
    logic [7:0]  e4;
    logic [24:0] mr4;
    logic [7:0]  ef4;
    logic [23:0] mf4;
    logic        s4_ub_reg, s4_zero_reg;
    logic [7:0]  s4_e_reg;
    logic [23:0] s4_mant_reg;
    logic [31:0] s4_dec_reg;

    always_comb
    begin
        if (s3_q_reg[28])
        begin
            mant4 = s3_q_reg[28:5];
            rb4   = s3_q_reg[4];
            st4   = (|s3_q_reg[3:0]) | s3_st_reg;
            e4    = 8'd129 - {4'd0, s3_lz_reg};
        end
        else if (s3_q_reg[27])
        begin
            mant4 = s3_q_reg[27:4];
            rb4   = s3_q_reg[3];
            st4   = (|s3_q_reg[2:0]) | s3_st_reg;
            e4    = 8'd128 - {4'd0, s3_lz_reg};
        end
        else
        begin
            mant4 = s3_q_reg[26:3];
            rb4   = s3_q_reg[2];
            st4   = (|s3_q_reg[1:0]) | s3_st_reg;
            e4    = 8'd127 - {4'd0, s3_lz_reg};
        end
        mr4 = {1'b0, mant4} + {24'd0, rb4 & (st4 | mant4[0])};
        if (mr4[24])
        begin
            mf4 = 24'h80_0000;
            ef4 = e4 + 8'd1;
        end
        else
        begin
            mf4 = mr4[23:0];
            ef4 = e4;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_ub_reg   <= s3_ub_reg;
            s4_zero_reg <= s3_zero_reg;
            s4_e_reg    <= ef4;
            s4_mant_reg <= mf4;
            s4_dec_reg  <= s3_zero_reg ? 32'd0 : {s3_sign_reg, ef4, mf4[22:0]};
        end
    end

    // stage 5: quotient to fixed point (2^-30 units), subtract one
    logic [3:0]  sh5;
    logic [32:0] fq5;
    localparam logic [32:0] ONE_FX = 33'h0_4000_0000;
    logic        s5_ub_reg, s5_neg_reg;
    logic [32:0] s5_d_reg;
    logic [31:0] s5_dec_reg;

    always_comb
    begin
        sh5 = 4'(s4_e_reg - 8'd120);
        fq5 = s4_zero_reg ? 33'd0 : ({9'd0, s4_mant_reg} << sh5);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_ub_reg  <= s4_ub_reg;
            s5_dec_reg <= s4_dec_reg;
            s5_neg_reg <= (fq5 < ONE_FX);
            s5_d_reg   <= (fq5 < ONE_FX) ? (ONE_FX - fq5) : (fq5 - ONE_FX);
        end
    end

    // stage 6: normalize the difference
    logic [5:0]  lz6;
    logic        s6_ub_reg, s6_neg_reg;
    logic [5:0]  s6_lz_reg;
    logic [32:0] s6_dn_reg;
    logic [31:0] s6_dec_reg;

    always_comb
    begin
        lz6 = 6'd0;
        for (int i = 0; i < 33; i++)
        begin
            if (s5_d_reg[i])
            begin
                lz6 = 6'(32 - i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_ub_reg  <= s5_ub_reg;
            s6_neg_reg <= s5_neg_reg;
            s6_dec_reg <= s5_dec_reg;
            s6_lz_reg  <= lz6;
            s6_dn_reg  <= s5_d_reg << lz6;
        end
    end

    // stage 7: round the difference and select the lane result
    logic [23:0] mant7;
    logic        inc7;
    logic [24:0] mr7;
    logic [7:0]  e7;
    logic [31:0] ub7;
    logic [31:0] res_reg;

    always_comb
    begin
        mant7 = s6_dn_reg[32:9];
        inc7  = s6_dn_reg[8] & ((|s6_dn_reg[7:0]) | mant7[0]);
        mr7   = {1'b0, mant7} + {24'd0, inc7};
        e7    = 8'd129 - {2'd0, s6_lz_reg};
        if (mr7[24])
        begin
            ub7 = {s6_neg_reg, e7 + 8'd1, 23'd0};
        end
        else
        begin
            ub7 = {s6_neg_reg, e7, mr7[22:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= s6_ub_reg ? ub7 : s6_dec_reg;
        end
    end

    assign res = res_reg;

endmodule

// ===== dv/vertex_normal_format_decoder_unit_tb.sv =====
// Testbench for vertex_normal_format_decoder_unit: directed and random normals on all formats,
// checked against a local conversion predictor with random input gaps and output backpressure.
// Depends on vnfd_pkg, vnfd_in_if, vnfd_out_if and the decoder RTL.
module vertex_normal_format_decoder_unit_tb
    import vnfd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // first selector value that yields the default normal
    localparam logic [2:0] FMT_DEFAULT = 3'd4;
    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } normal_t;

    // Predicts the decoded normal for each accepted transfer and checks results in order.
    class normal_scoreboard;
        normal_t expected_normals[$];
        int      mismatches;
        int      checked;
        int      fmt_seen[8];

        // round a double to the nearest single, ties to even; only normal magnitudes occur
        static function logic [31:0] round_to_single(real r);
            logic [63:0] d;
            logic [30:0] body;
            int          ex;
            d = $realtobits(r);
            if (d[62:0] == 63'd0)
            begin
                return {d[63], 31'd0};
            end
            ex = int'(d[62:52]) - 896;
            body = {ex[7:0], d[51:29]};
            if (d[28] && ((|d[27:0]) || body[0]))
            begin
                body = body + 31'd1;
            end
            return {d[63], body};
        endfunction

        static function real single_to_real(logic [31:0] s);
            logic [10:0] ex;
            if (s[30:0] == 31'd0)
            begin
                return 0.0;
            end
            ex = {3'd0, s[30:23]} + 11'd896;
            return $bitstoreal({s[31], ex, s[22:0], 29'd0});
        endfunction

        static function logic [31:0] half_to_single(logic [15:0] h);
            logic [10:0] man;
            int          ex;
            man = {1'b0, h[9:0]};
            if (h[14:10] == 5'h1F)
            begin
                return {h[15], BITS_INF[30:23], h[9:0], 13'd0};
            end
            if (h[14:10] == 5'd0)
            begin
                if (man == 11'd0)
                begin
                    return {h[15], 31'd0};
                end
                // normalize the denormal: shift until the hidden bit appears
                ex = 1;
                while (!man[10])
                begin
                    man = man << 1;
                    ex--;
                end
            end
            else
            begin
                ex = int'(h[14:10]);
            end
            ex += 112;
            return {h[15], ex[7:0], man[9:0], 13'd0};
        endfunction

        static function logic [31:0] dec10_to_single(logic [9:0] f);
            int v;
            v = int'(f);
            if (f[9])
            begin
                v -= 1024;
            end
            return round_to_single(real'(v) / 511.0);
        endfunction

        static function logic [31:0] ubyte_to_single(logic [7:0] b);
            logic [31:0] q;
            q = round_to_single(real'(b) / 127.5);
            return round_to_single(single_to_real(q) - 1.0);
        endfunction

        function void note_transfer(logic [2:0] op, logic [31:0] wx, logic [31:0] wy,
                                    logic [31:0] wz);
            normal_t n;
            fmt_seen[op]++;
            case (op)
                FMT_FLOAT3:
                begin
                    n.x = wx;
                    n.y = wy;
                    n.z = wz;
                end
                FMT_HALF2:
                begin
                    n.x = half_to_single(wx[15:0]);
                    n.y = half_to_single(wx[31:16]);
                    n.z = 32'd0;
                end
                FMT_DEC3N:
                begin
                    n.x = dec10_to_single(wx[9:0]);
                    n.y = dec10_to_single(wx[19:10]);
                    n.z = dec10_to_single(wx[29:20]);
                end
                FMT_UBYTE4N:
                begin
                    n.x = ubyte_to_single(wx[7:0]);
                    n.y = ubyte_to_single(wx[15:8]);
                    n.z = ubyte_to_single(wx[23:16]);
                end
                default:
                begin
                    n.x = 32'd0;
                    n.y = BITS_ONE;
                    n.z = 32'd0;
                end
            endcase
            expected_normals.push_back(n);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH %s: got %08h, expected %08h at %0t", what, got, want, $realtime);
            mismatches++;
        endtask

        task check_result(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz);
            normal_t n;
            checked++;
            if (expected_normals.size() == 0)
            begin
                report_mismatch("unexpected result norm_x", nx, 32'd0);
                return;
            end
            n = expected_normals.pop_front();
            if (nx !== n.x) report_mismatch("norm_x", nx, n.x);
            if (ny !== n.y) report_mismatch("norm_y", ny, n.y);
            if (nz !== n.z) report_mismatch("norm_z", nz, n.z);
        endtask

        function int pending();
            return expected_normals.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycle_count = 0;
    normal_scoreboard sb = new();

    vnfd_in_if  req_if();
    vnfd_out_if rsp_if();

    vertex_normal_format_decoder_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    always #6 clk = ~clk;

    // Watchdog: a correct run finishes far below this.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, sb.pending());
            $display("vertex_normal_format_decoder_unit_tb failed");
            $finish;
        end
    end

    // Result monitor: sample the output transfer at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            sb.check_result(rsp_if.norm_x, rsp_if.norm_y, rsp_if.norm_z);
        end
    end

    // Pick a gap length: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Output backpressure: alternate calm stretches with random stalls.
    initial
    begin
        int stall;
        int calm;
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            calm = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : 0;
            repeat (calm)
            begin
                @(negedge clk);
                rsp_if.ready = 1'b1;
            end
            stall = pick_gap();
            repeat (stall)
            begin
                @(negedge clk);
                rsp_if.ready = 1'b0;
            end
            @(negedge clk);
            rsp_if.ready = 1'b1;
        end
    end

    // Send one normal: hold valid through the gap low, then present it until transferred.
    task send_normal(logic [2:0] op, logic [31:0] wx, logic [31:0] wy, logic [31:0] wz,
                     int gap);
        repeat (gap)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid  = 1'b1;
        req_if.op     = op;
        req_if.word_x = wx;
        req_if.word_y = wy;
        req_if.word_z = wz;
        do
        begin
            @(posedge clk);
        end
        while (!req_if.ready);
        sb.note_transfer(op, wx, wy, wz);
        @(negedge clk);
    endtask

    function automatic logic [15:0] random_half();
        logic [15:0] h;
        h = 16'($urandom);
        // bias toward the exponent extremes: denormals, zeros, Inf and NaN
        case ($urandom_range(0, 5))
            0: h[14:10] = 5'd0;
            1: h[14:10] = 5'h1F;
            2: h[9:0]   = 10'd0;
            default: ;
        endcase
        return h;
    endfunction

    initial
    begin
        logic [2:0]  op;
        logic [31:0] wx;
        int          roll;

        req_if.valid  = 1'b0;
        req_if.op     = FMT_FLOAT3;
        req_if.word_x = 32'd0;
        req_if.word_y = 32'd0;
        req_if.word_z = 32'd0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: pass-through extremes and a NaN payload.
        send_normal(FMT_FLOAT3, 32'd0, 32'hFFFF_FFFF, 32'h7FC0_1234, 0);
        send_normal(FMT_FLOAT3, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 0);
        // Half pairs: signed zeros, smallest and largest denormals, Inf, NaN, one, max.
        send_normal(FMT_HALF2, 32'h8000_0000, 32'h1234_5678, 32'h9ABC_DEF0, 0);
        send_normal(FMT_HALF2, 32'h03FF_0001, 32'd0, 32'd0, 1);
        send_normal(FMT_HALF2, 32'hFC00_7C00, 32'd0, 32'd0, 0);
        send_normal(FMT_HALF2, 32'h7E01_FDFF, 32'd0, 32'd0, 0);
        send_normal(FMT_HALF2, 32'h7BFF_3C00, 32'd0, 32'd0, 2);
        send_normal(FMT_HALF2, 32'h8001_83FF, 32'd0, 32'd0, 0);
        // DEC3N: -512, -1, +511, zero, and ignored top bits.
        send_normal(FMT_DEC3N, {2'b11, 10'h200, 10'h3FF, 10'h1FF}, 32'd0, 32'd0, 0);
        send_normal(FMT_DEC3N, {2'b00, 10'h000, 10'h001, 10'h201}, 32'hFFFF_FFFF, 32'd0, 0);
        send_normal(FMT_DEC3N, 32'hC000_0000, 32'd0, 32'd0, 0);
        // UBYTE4N: bytes 0, 255, 127, 128 with the ignored byte set.
        send_normal(FMT_UBYTE4N, 32'hFF7F_FF00, 32'd0, 32'd0, 0);
        send_normal(FMT_UBYTE4N, 32'h0080_00FF, 32'd0, 32'hFFFF_FFFF, 0);
        // Every default selector value.
        for (int k = 0; k < 4; k++)
        begin
            send_normal(FMT_DEFAULT + 3'(k), $urandom, $urandom, $urandom, 0);
        end

        // Random: all formats, with half payloads biased to the special encodings.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            roll = $urandom_range(0, 9);
            op = roll < 2 ? FMT_FLOAT3 : roll < 4 ? FMT_HALF2 : roll < 6 ? FMT_DEC3N :
                 roll < 8 ? FMT_UBYTE4N : FMT_DEFAULT + 3'($urandom_range(0, 3));
            wx = $urandom;
            if (op == FMT_HALF2 && $urandom_range(0, 1))
            begin
                wx = {random_half(), random_half()};
            end
            send_normal(op, wx, $urandom, $urandom, pick_gap());
        end
        req_if.valid = 1'b0;

        // Drain, then allow the pipeline depth for anything unexpected.
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 8) @(posedge clk);

        $display("sent %0d normals: float3 %0d, half pair %0d, dec3n %0d, ubyte4n %0d",
                 sb.checked, sb.fmt_seen[FMT_FLOAT3], sb.fmt_seen[FMT_HALF2],
                 sb.fmt_seen[FMT_DEC3N], sb.fmt_seen[FMT_UBYTE4N]);
        $display("%0d results checked under random gaps and stalls, %0d mismatches",
                 sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
        begin
            $display("vertex_normal_format_decoder_unit_tb passed");
        end
        else
        begin
            $display("vertex_normal_format_decoder_unit_tb failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/vnfd_pkg.sv
hdl/vnfd_in_if.sv
hdl/vnfd_out_if.sv
hdl/vnfd_lane.sv
hdl/vertex_normal_format_decoder_unit.sv
dv/vertex_normal_format_decoder_unit_tb.sv
